/* hw/rtl/gmo_pkg.sv */
`default_nettype none
package gmo_pkg;

  localparam int CORDIC_STEPS = 24;

  localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_SCALE_COUNT  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RD_A, ST_RD_B, ST_CAP, ST_WR,
    ST_DIFF, ST_MULX, ST_MULY, ST_INIT, ST_ITER, ST_OUT
  } state_t;

  typedef struct packed {
    logic load;
    logic rd_a;
    logic rd_b;
    logic cap;
    logic wr;
    logic diff;
    logic mul_x;
    logic mul_y;
    logic init;
    logic step;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic interior;
    logic iter_done;
    logic out_free;
  } dp_status_t;

  // atan(2^-i) in 2^32 units of a full turn
  function automatic logic [31:0] turn_atan(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/gmo_if.sv */
`default_nettype none
interface pixel_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface result_if;
  logic        valid;
  logic        ready;
  logic [17:0] magnitude;
  logic [15:0] angle;
  logic [11:0] row;
  logic [9:0]  col;
  logic [3:0]  scale;
  logic        last;
  modport source (output valid, output magnitude, output angle, output row, output col,
                  output scale, output last, input ready);
  modport sink (input valid, input magnitude, input angle, input row, input col,
                input scale, input last, output ready);
endinterface
`default_nettype wire

/* hw/rtl/gmo_ctrl.sv */
`default_nettype none
module gmo_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire gmo_pkg::dp_status_t status,
  output gmo_pkg::dp_cmd_t        cmd
);
  gmo_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= gmo_pkg::ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      gmo_pkg::ST_IDLE: if (in_valid) state_next = gmo_pkg::ST_RD_A;
      gmo_pkg::ST_RD_A: state_next = gmo_pkg::ST_RD_B;
      gmo_pkg::ST_RD_B: state_next = gmo_pkg::ST_CAP;
      gmo_pkg::ST_CAP:  state_next = gmo_pkg::ST_WR;
      gmo_pkg::ST_WR: begin
        state_next = status.interior ? gmo_pkg::ST_DIFF : gmo_pkg::ST_IDLE;
      end
      gmo_pkg::ST_DIFF: state_next = gmo_pkg::ST_MULX;
      gmo_pkg::ST_MULX: state_next = gmo_pkg::ST_MULY;
      gmo_pkg::ST_MULY: state_next = gmo_pkg::ST_INIT;
      gmo_pkg::ST_INIT: state_next = gmo_pkg::ST_ITER;
      gmo_pkg::ST_ITER: if (status.iter_done) state_next = gmo_pkg::ST_OUT;
      gmo_pkg::ST_OUT:  if (status.out_free) state_next = gmo_pkg::ST_IDLE;
      default:          state_next = gmo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      gmo_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      gmo_pkg::ST_RD_A: cmd.rd_a = 1'b1;
      gmo_pkg::ST_RD_B: cmd.rd_b = 1'b1;
      gmo_pkg::ST_CAP:  cmd.cap = 1'b1;
      gmo_pkg::ST_WR:   cmd.wr = 1'b1;
      gmo_pkg::ST_DIFF: cmd.diff = 1'b1;
      gmo_pkg::ST_MULX: cmd.mul_x = 1'b1;
      gmo_pkg::ST_MULY: cmd.mul_y = 1'b1;
      gmo_pkg::ST_INIT: cmd.init = 1'b1;
      gmo_pkg::ST_ITER: cmd.step = 1'b1;
      gmo_pkg::ST_OUT:  cmd.out_load = status.out_free;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

/* hw/rtl/gmo_datapath.sv */
`default_nettype none
module gmo_datapath #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [12:0]        cfg_data,
  input  wire logic [15:0]        pixel,
  input  wire gmo_pkg::dp_cmd_t   cmd,
  output gmo_pkg::dp_status_t     status,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [17:0]             magnitude,
  output logic [15:0]             angle,
  output logic [11:0]             row,
  output logic [9:0]              col,
  output logic [3:0]              scale,
  output logic                    last
);
  localparam int AW     = $clog2(MAX_WIDTH);
  localparam int PB     = PIXEL_BITS;
  localparam int SQW    = 2 * PB + 1;
  localparam int XW     = PB + 20;
  localparam int ITER_N = (PB + 1 > gmo_pkg::CORDIC_STEPS) ? PB + 1 : gmo_pkg::CORDIC_STEPS;
  localparam int SW     = $clog2(ITER_N);

  logic [10:0] frame_width;
  logic [12:0] frame_height;
  logic [4:0]  scale_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= 11'd640;
      frame_height <= 13'd480;
      scale_count  <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        gmo_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data[10:0];
        gmo_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        gmo_pkg::CFG_SCALE_COUNT:  scale_count  <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // effective sizes after clamping
  logic [15:0] w16;
  logic [12:0] h_eff;
  logic [4:0]  sc_eff;
  always_comb begin
    if (frame_width < 11'd3) w16 = 16'd3;
    else if (16'(frame_width) > 16'(MAX_WIDTH)) w16 = 16'(MAX_WIDTH);
    else w16 = 16'(frame_width);
    if (frame_height < 13'd3) h_eff = 13'd3;
    else if (frame_height > 13'd4096) h_eff = 13'd4096;
    else h_eff = frame_height;
    if (scale_count == 5'd0) sc_eff = 5'd1;
    else if (scale_count > 5'd16) sc_eff = 5'd16;
    else sc_eff = scale_count;
  end

  logic [AW-1:0] col_cnt, cur_c;
  logic [11:0]   row_cnt, cur_r;
  logic [3:0]    scl_cnt, cur_s;
  logic [PB-1:0] pix_q;

  // position of the incoming pixel, wrapped for a shrunk size
  logic [AW-1:0] c0;
  logic [12:0]   r0;
  logic [4:0]    s0;
  always_comb begin
    c0 = col_cnt;
    r0 = 13'(row_cnt);
    s0 = 5'(scl_cnt);
    if (16'(col_cnt) >= w16) begin
      c0 = '0;
      r0 = r0 + 13'd1;
    end
    if (r0 >= h_eff) begin
      r0 = '0;
      s0 = s0 + 5'd1;
    end
    if (s0 >= sc_eff) s0 = '0;
  end

  // advance after the current pixel
  logic [AW:0]  c1;
  logic [12:0]  r1;
  logic [4:0]   s1;
  always_comb begin
    c1 = (AW+1)'(cur_c) + 1'b1;
    r1 = 13'(cur_r);
    s1 = 5'(cur_s);
    if (16'(c1) >= w16) begin
      c1 = '0;
      r1 = r1 + 13'd1;
      if (r1 >= h_eff) begin
        r1 = '0;
        s1 = s1 + 5'd1;
        if (s1 >= sc_eff) s1 = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
      scl_cnt <= '0;
    end else if (cmd.wr) begin
      col_cnt <= AW'(c1);
      row_cnt <= 12'(r1);
      scl_cnt <= 4'(s1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix_q <= PB'(pixel);
      cur_c <= c0;
      cur_r <= 12'(r0);
      cur_s <= 4'(s0);
    end
  end

  assign status.interior = (cur_r >= 12'd2) && (cur_c != '0) &&
                           (16'(cur_c) <= w16 - 16'd2);

  // line stores
  logic [PB-1:0] older_mem [MAX_WIDTH];
  logic [PB-1:0] newer_mem [MAX_WIDTH];
  logic [PB-1:0] older_q, newer_q, up, left, right, newc;
  logic [AW-1:0] older_addr, newer_addr;

  assign older_addr = cmd.rd_b ? cur_c - 1'b1 : cur_c;
  assign newer_addr = cmd.rd_b ? cur_c + 1'b1 : cur_c;

  always_ff @(posedge clk) begin
    if (cmd.rd_a || cmd.rd_b) begin
      older_q <= older_mem[older_addr];
      newer_q <= newer_mem[newer_addr];
    end
    if (cmd.wr) begin
      older_mem[cur_c] <= newc;
      newer_mem[cur_c] <= pix_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_b) begin
      up   <= older_q;
      newc <= newer_q;
    end
    if (cmd.cap) begin
      left  <= older_q;
      right <= newer_q;
    end
  end

  // gradient, squares
  logic signed [PB:0]     dx, dy;
  logic [2*PB-1:0]        sqx, sqy;
  logic signed [2*PB+1:0] px, py;
  assign px = dx * dx;
  assign py = dy * dy;

  always_ff @(posedge clk) begin
    if (cmd.diff) begin
      dx <= $signed({1'b0, right}) - $signed({1'b0, left});
      dy <= $signed({1'b0, pix_q}) - $signed({1'b0, up});
    end
    if (cmd.mul_x) sqx <= (2*PB)'(px);
    if (cmd.mul_y) sqy <= (2*PB)'(py);
  end

  // shared iteration: bitwise root and CORDIC
  logic [SW-1:0]       step;
  logic [SQW-1:0]      rem;
  logic [SQW:0]        q, sbit, qb;
  logic signed [XW-1:0] x, y, xs, ys;
  logic [31:0]         acc;
  logic                zero;

  assign qb = q + sbit;
  assign xs = x >>> step;
  assign ys = y >>> step;
  assign status.iter_done = (step == SW'(ITER_N - 1));

  always_ff @(posedge clk) begin
    if (cmd.init) begin
      step <= '0;
      rem  <= SQW'(sqx) + SQW'(sqy);
      q    <= '0;
      sbit <= (SQW+1)'(1) << (2 * PB);
      zero <= (dx == '0) && (dy == '0);
      if (dx < 0) begin
        x   <= (-XW'(dx)) <<< 16;
        y   <= (-XW'(dy)) <<< 16;
        acc <= 32'h8000_0000;
      end else begin
        x   <= XW'(dx) <<< 16;
        y   <= XW'(dy) <<< 16;
        acc <= '0;
      end
    end else if (cmd.step) begin
      step <= step + 1'b1;
      if (32'(step) < PB + 1) begin
        if ((SQW+1)'(rem) >= qb) begin
          rem <= SQW'((SQW+1)'(rem) - qb);
          q   <= (q >> 1) + sbit;
        end else begin
          q <= q >> 1;
        end
        sbit <= sbit >> 2;
      end
      if (32'(step) < gmo_pkg::CORDIC_STEPS) begin
        if (!y[XW-1]) begin
          x   <= x + ys;
          y   <= y - xs;
          acc <= acc + gmo_pkg::turn_atan(5'(step));
        end else begin
          x   <= x - ys;
          y   <= y + xs;
          acc <= acc - gmo_pkg::turn_atan(5'(step));
        end
      end
    end
  end

  // result
  logic [PB+1:0] root;
  logic [15:0]   ang;
  assign root = (SQW+1)'(rem) > q ? (PB+2)'(q) + 1'b1 : (PB+2)'(q);
  assign ang  = zero ? 16'd0 : acc[31:16] + 16'(acc[15]);
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      magnitude <= (32'(root) > 32'h3FFFF) ? 18'h3FFFF : 18'(root);
      angle     <= ang;
      row       <= cur_r - 12'd1;
      col       <= 10'(cur_c);
      scale     <= cur_s;
      last      <= (13'(cur_r) == h_eff - 13'd1) && (16'(cur_c) == w16 - 16'd2) &&
                   (5'(cur_s) == sc_eff - 5'd1);
    end
  end
endmodule
`default_nettype wire

/* hw/rtl/gradient_magnitude_orientation.sv */
// One pixel is in work at a time: a new pixel is accepted only in idle, after the
//   line store read sequence and, for an interior pixel, after the shared root/CORDIC unit
//   (24 steps) has run and the output register is free to take its result.
// A finished result waits in the output register while the next pixel is taken.
// Reset (rst, synchronous): counters, handshake state and size registers cleared
//   to 640 x 480, one scale; line stores are not cleared.
`default_nettype none
module gradient_magnitude_orientation #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [12:0] cfg_data,
  pixel_if.sink            pixels,
  result_if.source         results
);
  gmo_pkg::dp_cmd_t    cmd;
  gmo_pkg::dp_status_t status;
  logic                in_ready;

  assign pixels.ready = in_ready;

  gmo_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pixels.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  gmo_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel     (pixels.pixel),
    .cmd       (cmd),
    .status    (status),
    .out_ready (results.ready),
    .out_valid (results.valid),
    .magnitude (results.magnitude),
    .angle     (results.angle),
    .row       (results.row),
    .col       (results.col),
    .scale     (results.scale),
    .last      (results.last)
  );

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (pixels.valid && in_ready) |=> !in_ready)
    else $error("pixel taken while previous one in work");
  a_col_interior: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.col != 10'd0))
    else $error("result on border column");
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!results.valid || results.ready))
    else $error("result overwritten before transaction");
`endif
endmodule
`default_nettype wire

/* bench/gmo_bench_pkg.sv */
`timescale 1ns / 1ps
package gmo_bench_pkg;

  typedef struct packed {
    logic [17:0] magnitude;
    logic [15:0] angle;
    logic [11:0] row;
    logic [9:0]  col;
    logic [3:0]  scale;
    logic        last;
  } gradient_t;

  localparam logic [31:0] TURN_ATAN [24] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  class gradient_scoreboard;
    logic [15:0] older_row [1024];
    logic [15:0] newer_row [1024];
    int unsigned width_reg, height_reg, scales_reg;
    int unsigned col_now, row_now, scale_now;
    gradient_t pending_q[$];
    int errors;

    function new();
      width_reg = 640;
      height_reg = 480;
      scales_reg = 1;
      col_now = 0;
      row_now = 0;
      scale_now = 0;
      errors = 0;
      foreach (older_row[i]) begin
        older_row[i] = '0;
        newer_row[i] = '0;
      end
    endfunction

    static function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    static function longint unsigned rounded_root(longint unsigned n);
      longint unsigned q, rem, b;
      q = 0;
      rem = n;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
        if (rem >= q + b) begin
          rem -= q + b;
          q = (q >> 1) + b;
        end else begin
          q >>= 1;
        end
        b >>= 2;
      end
      if (n > q * q + q) q += 1;
      return q;
    endfunction

    static function logic [15:0] turn_angle(longint dx, longint dy);
      logic [31:0] acc;
      longint x, y, xs, ys;
      acc = '0;
      if (dx == 0 && dy == 0) return '0;
      if (dx < 0) begin
        dx = -dx;
        dy = -dy;
        acc = 32'h8000_0000;
      end
      x = dx * 65536;
      y = dy * 65536;
      for (int i = 0; i < 24; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          acc += TURN_ATAN[i];
        end else begin
          x = x - ys;
          y = y + xs;
          acc -= TURN_ATAN[i];
        end
      end
      acc = acc + 32'h8000;
      return acc[31:16];
    endfunction

    function void write_reg(logic [1:0] idx, logic [12:0] val);
      case (idx)
        gmo_pkg::CFG_FRAME_WIDTH:  width_reg = val[10:0];
        gmo_pkg::CFG_FRAME_HEIGHT: height_reg = val[12:0];
        gmo_pkg::CFG_SCALE_COUNT:  scales_reg = val[4:0];
        default: ;
      endcase
    endfunction

    function void note_pixel(logic [15:0] p);
      int unsigned w, h, sc, c, r, s;
      longint dx, dy;
      longint unsigned mag;
      gradient_t g;
      w = clamp(width_reg, 3, 1024);
      h = clamp(height_reg, 3, 4096);
      sc = clamp(scales_reg, 1, 16);
      c = col_now;
      r = row_now;
      s = scale_now;
      if (c >= w) begin c = 0; r++; end
      if (r >= h) begin r = 0; s++; end
      if (s >= sc) s = 0;
      if (r >= 2 && c >= 1 && c <= w - 2) begin
        dx = longint'(newer_row[c + 1]) - longint'(older_row[c - 1]);
        dy = longint'(p) - longint'(older_row[c]);
        mag = rounded_root(longint'(dx * dx + dy * dy));
        if (mag > 64'h3FFFF) mag = 64'h3FFFF;
        g.magnitude = mag[17:0];
        g.angle = turn_angle(dx, dy);
        g.row = 12'(r - 1);
        g.col = 10'(c);
        g.scale = 4'(s);
        g.last = (r == h - 1 && c == w - 2 && s == sc - 1);
        pending_q.push_back(g);
      end
      older_row[c] = newer_row[c];
      newer_row[c] = p;
      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) begin
          r = 0;
          s++;
          if (s >= sc) s = 0;
        end
      end
      col_now = c;
      row_now = r;
      scale_now = s;
    endfunction

    function void report(string what);
      $display("mismatch: %s", what);
      errors++;
    endfunction

    function void check_result(gradient_t got);
      gradient_t want;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result %p", got));
        return;
      end
      want = pending_q.pop_front();
      if (got.magnitude !== want.magnitude)
        report($sformatf("magnitude %0d, want %0d", got.magnitude, want.magnitude));
      if (got.angle !== want.angle)
        report($sformatf("angle %0d, want %0d", got.angle, want.angle));
      if (got.row !== want.row) report($sformatf("row %0d, want %0d", got.row, want.row));
      if (got.col !== want.col) report($sformatf("col %0d, want %0d", got.col, want.col));
      if (got.scale !== want.scale)
        report($sformatf("scale %0d, want %0d", got.scale, want.scale));
      if (got.last !== want.last) report($sformatf("last %0b, want %0b", got.last, want.last));
    endfunction
  endclass

endpackage

/* bench/tb_gradient_magnitude_orientation.sv */
`timescale 1ns / 1ps
module tb_gradient_magnitude_orientation;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = gmo_pkg::CFG_FRAME_WIDTH;
  logic [12:0] cfg_data = '0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit done = 1'b0;

  pixel_if pixels ();
  result_if results ();

  gradient_magnitude_orientation dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .pixels(pixels.sink), .results(results.source)
  );

  gmo_bench_pkg::gradient_scoreboard board = new();

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    pixels.valid = 1'b0;
    pixels.pixel = '0;
    results.ready = 1'b0;
  end

  // receiver: random stalls, checks every transaction
  always @(posedge clk) begin
    if (!rst && results.valid && results.ready)
      board.check_result({results.magnitude, results.angle, results.row,
                          results.col, results.scale, results.last});
    results.ready <= !rst && ($urandom_range(99) >= recv_stall_pct);
  end

  // valid stays high after a transaction; the next call or drain() moves it
  task automatic send_pixel(logic [15:0] p);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      pixels.valid <= 1'b0;
      @(posedge clk);
    end
    pixels.valid <= 1'b1;
    pixels.pixel <= p;
    do @(posedge clk); while (!pixels.ready);
    board.note_pixel(p);
  endtask

  task automatic drain();
    pixels.valid <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_cfg(logic [1:0] idx, logic [12:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    board.write_reg(idx, val);
  endtask

  // size changes only between whole stacks so line stores are always filled first
  task automatic set_size(int w, int h, int sc);
    drain();
    write_cfg(gmo_pkg::CFG_FRAME_WIDTH, 13'(w));
    write_cfg(gmo_pkg::CFG_FRAME_HEIGHT, 13'(h));
    write_cfg(gmo_pkg::CFG_SCALE_COUNT, 13'(sc));
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] rand_pixel();
    case ($urandom_range(5))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(15));
      3: return 16'hFFF0 | 16'($urandom_range(15));
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  task automatic send_stack(int n);
    for (int i = 0; i < n; i++) send_pixel(rand_pixel());
  endtask

  initial begin : stimulus
    logic [15:0] directed [25];
    int w, h, sc;
    directed = '{16'd0, 16'd65535, 16'd0, 16'd65535, 16'd0,
                 16'd65535, 16'd0, 16'd65535, 16'd0, 16'd65535,
                 16'd100, 16'd100, 16'd100, 16'd100, 16'd100,
                 16'd0, 16'd65535, 16'd0, 16'd1, 16'd2,
                 16'd7, 16'd7, 16'd7, 16'd7, 16'd7};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // 5x5 frame, one scale: extremes, flat gradient and steep corners
    set_size(5, 5, 1);
    foreach (directed[i]) send_pixel(directed[i]);
    // clamping: out-of-range values act as the bound, 3x3 with 16 scales
    set_size(0, 1, 31);
    send_stack(9 * 16);
    set_size(30, 3, 1);
    send_stack(30 * 3);
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 56 : 23) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 56 : 23) : 0;
      for (int k = 0; k < 6; k++) begin
        w = $urandom_range(3, 8);
        h = $urandom_range(3, 7);
        sc = $urandom_range(1, 3);
        set_size(w, h, sc);
        send_stack(w * h * sc);
        if (k == 2) drain();
      end
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    done = 1'b1;
  end

  initial begin : finisher
    wait (done);
    if (board.errors == 0)
      $display("gradient_magnitude_orientation regression: pass");
    else
      $display("gradient_magnitude_orientation regression: fail");
    $finish;
  end

  initial begin : watchdog
    #20ms;
    $display("gradient_magnitude_orientation regression: fail");
    $finish;
  end

endmodule
